FILE: hdl/prmf_pkg.sv
// shared types and constants for the push-relabel max flow engine
`default_nettype none
package prmf_pkg;

  // fixed field widths of the item and result ports
  localparam int CMD_W     = 2;
  localparam int NODE_IN_W = 6;
  localparam int EDGE_W    = 16;
  localparam int OUT_W     = 22;
  localparam int HEIGHT_W  = 8;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_ADD_RD1,
    S_ADD_WR1,
    S_ADD_RD2,
    S_ADD_WR2,
    S_ZERO,
    S_RD,
    S_EVAL,
    S_PUSH1,
    S_PUSH2,
    S_WB,
    S_Q_RD,
    S_Q_GET,
    S_LOAD,
    S_FIN_RD,
    S_FIN_GET,
    S_DONE
  } state_t;

  // edge evaluation status from the shared unit
  typedef struct packed {
    logic usable;
    logic push;
  } eval_flags_t;

endpackage
`default_nettype wire

FILE: hdl/prmf_ram.sv
// generic single write port ram with registered read
`default_nettype none
module prmf_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/prmf_eval.sv
// shared edge evaluation unit: residual, push decision, amount, saturating add
`default_nettype none
module prmf_eval
  import prmf_pkg::*;
#(
  parameter int CAP_BITS = 16,
  parameter int EXW      = 24
) (
  input  wire logic                       sat_mode,
  input  wire logic                       nb,
  input  wire logic        [CAP_BITS-1:0] cap,
  input  wire logic signed [CAP_BITS:0]   flow,
  input  wire logic signed [EXW-1:0]      exu,
  input  wire logic        [HEIGHT_W-1:0] hu,
  input  wire logic        [HEIGHT_W-1:0] hv,
  input  wire logic        [EDGE_W-1:0]   add_w,
  output eval_flags_t                     flags,
  output logic signed      [EXW-1:0]      amt,
  output logic             [CAP_BITS-1:0] sat_sum
);

  localparam int RW = CAP_BITS + 2;
  localparam int SW = ((CAP_BITS > EDGE_W) ? CAP_BITS : EDGE_W) + 1;

  logic signed [RW-1:0]  res;
  logic signed [EXW-1:0] res_ext;
  logic signed [EXW-1:0] cap_ext;
  logic                  res_pos;
  logic                  h_fit;
  logic [SW-1:0]         sum;

  // residual capacity and admissibility
  always_comb begin
    res     = $signed({2'b00, cap}) - $signed({flow[CAP_BITS], flow});
    res_ext = EXW'(res);
    cap_ext = $signed({{(EXW-CAP_BITS){1'b0}}, cap});
    res_pos = !res[RW-1] && (res != '0);
    h_fit   = ({1'b0, hu} == ({1'b0, hv} + 9'd1));
    flags.usable = nb && (sat_mode || res_pos);
    flags.push   = nb && (sat_mode || (res_pos && h_fit));
    if (sat_mode) begin
      amt = cap_ext;
    end else begin
      amt = (exu < res_ext) ? exu : res_ext;
    end
  end

  // saturating capacity add
  always_comb begin
    sum = SW'(cap) + SW'(add_w);
    if (sum > SW'({CAP_BITS{1'b1}})) begin
      sat_sum = {CAP_BITS{1'b1}};
    end else begin
      sat_sum = CAP_BITS'(sum);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/push_relabel_max_flow.sv
// top level: FIFO push-relabel maximum flow engine with its sequencer
`default_nettype none
// The block keeps a capacity graph of up to MAX_NODES nodes in on-chip RAM and
// takes one command item at a time: clear, add edge or run. After reset it
// sweeps the capacity RAM once, one entry per cycle (MAX_NODES rounded up to a
// power of two, squared: 4096 entries at the default), and stalls input meanwhile.
// A clear writes n*n capacity entries for n nodes in use; an add edge reads and
// writes the forward entry, then the reverse entry. A run zeroes n*n flow
// entries, then fetches (S_RD) and evaluates (S_EVAL) each neighbor during
// source saturation and each discharge pass, with S_PUSH1 and S_PUSH2 for each
// push; the total follows the number of relabels and pushes the graph needs. All
// edge arithmetic goes through one shared evaluation unit fed from RAMs with one
// write and one registered read port. A run returns one result item holding the
// flow leaving the source; other commands return none.
module push_relabel_max_flow
  import prmf_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int CAP_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [NODE_IN_W-1:0]  in_from_node,
  input  wire logic [NODE_IN_W-1:0]  in_to_node,
  input  wire logic [EDGE_W-1:0]     in_edge_capacity,
  input  wire logic                  in_directed,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_W-1:0]           out_max_flow,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int NW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CNW   = NW + 1;
  localparam int MW    = 2 * NW;
  localparam int MDEP  = 1 << MW;
  localparam int NDEP  = 1 << NW;
  localparam int FW    = CAP_BITS + 1;
  localparam int EXW   = CAP_BITS + NW + 2;

  // configuration registers
  logic [CFG_W-1:0]     node_count_r;
  logic [NODE_IN_W-1:0] source_node_r;
  logic [NODE_IN_W-1:0] sink_node_r;

  // sequencer and datapath registers
  state_t                state_r, state_nxt;
  logic [NW-1:0]         i_r, i_nxt;
  logic [NW-1:0]         j_r, j_nxt;
  logic [NW-1:0]         u_r, u_nxt;
  logic [NW-1:0]         v_r, v_nxt;
  logic [NW-1:0]         s_r, s_nxt;
  logic [NW-1:0]         t_r, t_nxt;
  logic [CNW-1:0]        n_r, n_nxt;
  logic signed [EXW-1:0] exu_r, exu_nxt;
  logic [HEIGHT_W-1:0]   hu_r, hu_nxt;
  logic [HEIGHT_W-1:0]   lowest_r, lowest_nxt;
  logic                  found_r, found_nxt;
  logic                  sat_r, sat_nxt;
  logic signed [EXW-1:0] amt_r, amt_nxt;
  logic signed [FW-1:0]  flow_r, flow_nxt;
  logic signed [EXW-1:0] exv_r, exv_nxt;
  logic [EDGE_W-1:0]     w_r, w_nxt;
  logic                  dir_r, dir_nxt;
  logic [NW-1:0]         q_head_r, q_head_nxt;
  logic [CNW-1:0]        q_count_r, q_count_nxt;
  logic [OUT_W-1:0]      res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_max_flow_r, out_max_flow_nxt;

  // ram ports
  logic                 cn_we;
  logic [MW-1:0]        cn_waddr, cn_raddr;
  logic [CAP_BITS:0]    cn_wdata, cn_rdata;
  logic                 fl_we;
  logic [MW-1:0]        fl_waddr, fl_raddr;
  logic [FW-1:0]        fl_wdata, fl_rdata;
  logic                 ex_we;
  logic [NW-1:0]        ex_waddr, ex_raddr;
  logic [EXW-1:0]       ex_wdata, ex_rdata;
  logic                 ht_we;
  logic [NW-1:0]        ht_waddr, ht_raddr;
  logic [HEIGHT_W-1:0]  ht_wdata, ht_rdata;
  logic                 q_we;
  logic [NW-1:0]        q_waddr, q_raddr;
  logic [NW-1:0]        q_wdata, q_rdata;

  // shared unit ports
  eval_flags_t           ev_flags;
  logic signed [EXW-1:0] ev_amt;
  logic [CAP_BITS-1:0]   ev_sat_sum;

  // helpers
  logic [CNW-1:0]        n_w;
  logic                  j_last, i_last, v_last;
  logic                  in_acc;
  logic [NW+1:0]         tail_sum;
  logic [NW-1:0]         q_tail;
  logic signed [FW-1:0]  new_flow;
  logic signed [EXW-1:0] total;
  logic                  enq;

  prmf_ram #(.W(CAP_BITS + 1), .DEPTH(MDEP)) u_cn_ram (
    .clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
    .raddr(cn_raddr), .rdata(cn_rdata)
  );

  prmf_ram #(.W(FW), .DEPTH(MDEP)) u_fl_ram (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  prmf_ram #(.W(EXW), .DEPTH(NDEP)) u_ex_ram (
    .clk(clk), .we(ex_we), .waddr(ex_waddr), .wdata(ex_wdata),
    .raddr(ex_raddr), .rdata(ex_rdata)
  );

  prmf_ram #(.W(HEIGHT_W), .DEPTH(NDEP)) u_ht_ram (
    .clk(clk), .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata),
    .raddr(ht_raddr), .rdata(ht_rdata)
  );

  prmf_ram #(.W(NW), .DEPTH(NDEP)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  prmf_eval #(.CAP_BITS(CAP_BITS), .EXW(EXW)) u_eval (
    .sat_mode(sat_r),
    .nb(cn_rdata[CAP_BITS]),
    .cap(cn_rdata[CAP_BITS-1:0]),
    .flow($signed(fl_rdata)),
    .exu(exu_r),
    .hu(hu_r),
    .hv(ht_rdata),
    .add_w(w_r),
    .flags(ev_flags),
    .amt(ev_amt),
    .sat_sum(ev_sat_sum)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_max_flow = out_max_flow_r;
  assign in_acc       = in_valid && !in_stall;

  // nodes in use and loop end flags
  always_comb begin
    if ({25'd0, node_count_r} > 32'(MAX_NODES)) begin
      n_w = CNW'(MAX_NODES);
    end else begin
      n_w = CNW'(node_count_r);
    end
    j_last   = ({1'b0, j_r} == (n_r - CNW'(1)));
    i_last   = ({1'b0, i_r} == (n_r - CNW'(1)));
    v_last   = ({1'b0, v_r} == (n_r - CNW'(1)));
    tail_sum = {2'b00, q_head_r} + {1'b0, q_count_r};
    if (tail_sum >= (NW + 2)'(MAX_NODES)) begin
      q_tail = NW'(tail_sum - (NW + 2)'(MAX_NODES));
    end else begin
      q_tail = NW'(tail_sum);
    end
    new_flow = FW'(EXW'(flow_r) + amt_r);
    total    = -$signed(ex_rdata);
    enq      = (amt_r > 0) && (exv_r == '0) && (v_r != s_r) && (v_r != t_r) &&
               (q_count_r < CNW'(MAX_NODES));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= CFG_W'(64);
      source_node_r <= '0;
      sink_node_r   <= NODE_IN_W'(63);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_r  <= cfg_data;
        CFG_SOURCE:     source_node_r <= cfg_data[NODE_IN_W-1:0];
        CFG_SINK:       sink_node_r   <= cfg_data[NODE_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      i_r         <= '0;
      j_r         <= '0;
      q_head_r    <= '0;
      q_count_r   <= '0;
      sat_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      q_head_r    <= q_head_nxt;
      q_count_r   <= q_count_nxt;
      sat_r       <= sat_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    u_r            <= u_nxt;
    v_r            <= v_nxt;
    s_r            <= s_nxt;
    t_r            <= t_nxt;
    n_r            <= n_nxt;
    exu_r          <= exu_nxt;
    hu_r           <= hu_nxt;
    lowest_r       <= lowest_nxt;
    amt_r          <= amt_nxt;
    flow_r         <= flow_nxt;
    exv_r          <= exv_nxt;
    w_r            <= w_nxt;
    dir_r          <= dir_nxt;
    res_r          <= res_nxt;
    out_max_flow_r <= out_max_flow_nxt;
  end

  // sequencer: next state, ram controls and datapath updates
  always_comb begin
    state_nxt        = state_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    u_nxt            = u_r;
    v_nxt            = v_r;
    s_nxt            = s_r;
    t_nxt            = t_r;
    n_nxt            = n_r;
    exu_nxt          = exu_r;
    hu_nxt           = hu_r;
    lowest_nxt       = lowest_r;
    found_nxt        = found_r;
    sat_nxt          = sat_r;
    amt_nxt          = amt_r;
    flow_nxt         = flow_r;
    exv_nxt          = exv_r;
    w_nxt            = w_r;
    dir_nxt          = dir_r;
    q_head_nxt       = q_head_r;
    q_count_nxt      = q_count_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    out_max_flow_nxt = out_max_flow_r;

    cn_we = 1'b0; cn_waddr = {u_r, v_r}; cn_wdata = '0; cn_raddr = {u_r, v_r};
    fl_we = 1'b0; fl_waddr = {u_r, v_r}; fl_wdata = '0; fl_raddr = {u_r, v_r};
    ex_we = 1'b0; ex_waddr = v_r; ex_wdata = '0; ex_raddr = v_r;
    ht_we = 1'b0; ht_waddr = v_r; ht_wdata = '0; ht_raddr = v_r;
    q_we  = 1'b0; q_waddr = q_tail; q_wdata = v_r; q_raddr = q_head_r;

    // result register drains independently
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // power-on sweep of the capacity ram
      S_INIT: begin
        cn_we    = 1'b1;
        cn_waddr = {i_r, j_r};
        {i_nxt, j_nxt} = {i_r, j_r} + MW'(1);
        if ({i_r, j_r} == {MW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      // take one command item
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_CLEAR: begin
              n_nxt = n_w;
              i_nxt = '0;
              j_nxt = '0;
              q_head_nxt  = '0;
              q_count_nxt = '0;
              if (n_w != '0) begin
                state_nxt = S_CLR;
              end
            end
            CMD_ADD: begin
              u_nxt   = NW'(in_from_node);
              v_nxt   = NW'(in_to_node);
              w_nxt   = in_edge_capacity;
              dir_nxt = in_directed;
              if ((in_from_node != in_to_node) &&
                  ({26'd0, in_from_node} < 32'(MAX_NODES)) &&
                  ({26'd0, in_to_node} < 32'(MAX_NODES))) begin
                state_nxt = S_ADD_RD1;
              end
            end
            CMD_RUN: begin
              n_nxt = n_w;
              s_nxt = NW'(source_node_r);
              t_nxt = NW'(sink_node_r);
              i_nxt = '0;
              j_nxt = '0;
              if (({26'd0, source_node_r} >= 32'(n_w)) ||
                  ({26'd0, sink_node_r} >= 32'(n_w)) ||
                  (source_node_r == sink_node_r)) begin
                res_nxt   = '0;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_ZERO;
              end
            end
            default: ;
          endcase
        end
      end

      // clear capacity and neighbor entries of nodes in use
      S_CLR: begin
        cn_we    = 1'b1;
        cn_waddr = {i_r, j_r};
        if (j_last) begin
          j_nxt = '0;
          i_nxt = i_r + NW'(1);
          if (i_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          j_nxt = j_r + NW'(1);
        end
      end

      // add edge: forward entry, then reverse entry
      S_ADD_RD1: begin
        cn_raddr  = {u_r, v_r};
        state_nxt = S_ADD_WR1;
      end
      S_ADD_WR1: begin
        cn_we     = 1'b1;
        cn_waddr  = {u_r, v_r};
        cn_wdata  = {1'b1, ev_sat_sum};
        state_nxt = S_ADD_RD2;
      end
      S_ADD_RD2: begin
        cn_raddr  = {v_r, u_r};
        state_nxt = S_ADD_WR2;
      end
      S_ADD_WR2: begin
        cn_we     = 1'b1;
        cn_waddr  = {v_r, u_r};
        cn_wdata  = dir_r ? {1'b1, cn_rdata[CAP_BITS-1:0]} : {1'b1, ev_sat_sum};
        state_nxt = S_IDLE;
      end

      // zero flows, excesses and heights of nodes in use
      S_ZERO: begin
        fl_we    = 1'b1;
        fl_waddr = {i_r, j_r};
        if (j_r == '0) begin
          ex_we    = 1'b1;
          ex_waddr = i_r;
          ht_we    = 1'b1;
          ht_waddr = i_r;
        end
        if (j_last) begin
          j_nxt = '0;
          i_nxt = i_r + NW'(1);
          if (i_last) begin
            q_head_nxt  = '0;
            q_count_nxt = '0;
            u_nxt       = s_r;
            v_nxt       = '0;
            sat_nxt     = 1'b1;
            exu_nxt     = '0;
            hu_nxt      = HEIGHT_W'(n_r);
            state_nxt   = S_RD;
          end
        end else begin
          j_nxt = j_r + NW'(1);
        end
      end

      // fetch edge u->v and node v
      S_RD: begin
        cn_raddr  = {u_r, v_r};
        fl_raddr  = {u_r, v_r};
        ex_raddr  = v_r;
        ht_raddr  = v_r;
        state_nxt = S_EVAL;
      end

      // evaluate edge through the shared unit
      S_EVAL: begin
        if (ev_flags.usable && !sat_r) begin
          if (!found_r || (ht_rdata < lowest_r)) begin
            lowest_nxt = ht_rdata;
          end
          found_nxt = 1'b1;
        end
        if (ev_flags.push) begin
          amt_nxt   = ev_amt;
          flow_nxt  = $signed(fl_rdata);
          exv_nxt   = $signed(ex_rdata);
          state_nxt = S_PUSH1;
        end else if (v_last) begin
          if (sat_r || !(found_r || ev_flags.usable)) begin
            state_nxt = S_WB;
          end else begin
            hu_nxt     = (lowest_nxt == {HEIGHT_W{1'b1}}) ? lowest_nxt :
                         lowest_nxt + HEIGHT_W'(1);
            v_nxt      = '0;
            found_nxt  = 1'b0;
            state_nxt  = S_RD;
          end
        end else begin
          v_nxt     = v_r + NW'(1);
          state_nxt = S_RD;
        end
      end

      // push: forward flow, excess of v, enqueue
      S_PUSH1: begin
        fl_we    = 1'b1;
        fl_waddr = {u_r, v_r};
        fl_wdata = new_flow;
        ex_we    = 1'b1;
        ex_waddr = v_r;
        ex_wdata = exv_r + amt_r;
        exu_nxt  = exu_r - amt_r;
        if (enq) begin
          q_we        = 1'b1;
          q_waddr     = q_tail;
          q_wdata     = v_r;
          q_count_nxt = q_count_r + CNW'(1);
        end
        state_nxt = S_PUSH2;
      end

      // push: reverse flow, then next neighbor, relabel or write back
      S_PUSH2: begin
        fl_we    = 1'b1;
        fl_waddr = {v_r, u_r};
        fl_wdata = -new_flow;
        if (!sat_r && (exu_r == '0)) begin
          state_nxt = S_WB;
        end else if (v_last) begin
          if (sat_r || !found_r) begin
            state_nxt = S_WB;
          end else begin
            hu_nxt    = (lowest_r == {HEIGHT_W{1'b1}}) ? lowest_r :
                        lowest_r + HEIGHT_W'(1);
            v_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end else begin
          v_nxt     = v_r + NW'(1);
          state_nxt = S_RD;
        end
      end

      // write back excess and height of the node just handled
      S_WB: begin
        ex_we     = 1'b1;
        ex_waddr  = u_r;
        ex_wdata  = exu_r;
        ht_we     = 1'b1;
        ht_waddr  = u_r;
        ht_wdata  = hu_r;
        sat_nxt   = 1'b0;
        state_nxt = S_Q_RD;
      end

      // pop the next active node
      S_Q_RD: begin
        if (q_count_r == '0) begin
          state_nxt = S_FIN_RD;
        end else begin
          q_raddr     = q_head_r;
          q_head_nxt  = ({1'b0, q_head_r} == CNW'(MAX_NODES - 1)) ? '0 :
                        q_head_r + NW'(1);
          q_count_nxt = q_count_r - CNW'(1);
          state_nxt   = S_Q_GET;
        end
      end
      S_Q_GET: begin
        u_nxt    = q_rdata;
        ex_raddr = q_rdata;
        ht_raddr = q_rdata;
        if (({1'b0, q_rdata} < n_r) && (q_rdata != s_r) && (q_rdata != t_r)) begin
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_Q_RD;
        end
      end

      // load node state and start a discharge if it has excess
      S_LOAD: begin
        exu_nxt    = $signed(ex_rdata);
        hu_nxt     = ht_rdata;
        v_nxt      = '0;
        found_nxt  = 1'b0;
        lowest_nxt = '0;
        if ($signed(ex_rdata) > 0) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_Q_RD;
        end
      end

      // flow value from the source excess
      S_FIN_RD: begin
        ex_raddr  = s_r;
        state_nxt = S_FIN_GET;
      end
      S_FIN_GET: begin
        res_nxt   = (total > 0) ? OUT_W'(total) : '0;
        state_nxt = S_DONE;
      end

      // hand the result item to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_max_flow_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // queue count never exceeds MAX_NODES
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= CNW'(MAX_NODES))
    else $error("active queue overfilled");

  // a result item only appears after a run has finished
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result item without a finished run");

  // discharge pushes always move a positive amount
  a_push_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH1 && !sat_r) |-> (amt_r > 0))
    else $error("discharge push of non-positive amount");

  // a node load only follows a queue pop
  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> $past(state_r == S_Q_GET))
    else $error("node load out of sequence");

endmodule
`default_nettype wire

FILE: sim/prmf_checker.sv
// checker for the push-relabel max flow engine: watches the ports, predicts and compares flows
module prmf_checker
  import prmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [NODE_IN_W-1:0] in_from_node,
  input  logic [NODE_IN_W-1:0] in_to_node,
  input  logic [EDGE_W-1:0]    in_edge_capacity,
  input  logic                 in_directed,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_W-1:0]     out_max_flow,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX = 64;
  localparam int CAP_MAX = 65535;
  localparam int DUE_DEPTH = 16;

  // predicted graph and per-run state
  int     cap_m [NMAX][NMAX];
  longint flow_m [NMAX][NMAX];
  bit     nbr [NMAX][NMAX];
  longint excess [NMAX];
  int     height [NMAX];
  int     act_q [NMAX];
  int     q_head, q_count;
  int     cfg_nodes, cfg_src, cfg_snk;
  logic [OUT_W-1:0] flows_due [DUE_DEPTH];
  int     due_wr, due_rd;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic int live_nodes();
    return cfg_nodes > NMAX ? NMAX : cfg_nodes;
  endfunction

  function automatic void push_active(int v);
    if (q_count < NMAX) begin
      act_q[(q_head + q_count) % NMAX] = v;
      q_count++;
    end
  endfunction

  function automatic void move_flow(int u, int v, longint amt, int s, int t);
    bit was_idle;
    was_idle = (excess[v] == 0);
    flow_m[u][v] += amt;
    flow_m[v][u] -= amt;
    excess[u] -= amt;
    excess[v] += amt;
    if (was_idle && amt > 0 && v != s && v != t) push_active(v);
  endfunction

  // push from u while it has excess, relabel when a full scan leaves excess
  function automatic void drain_node(int u, int n, int s, int t);
    int lowest;
    bit found;
    longint resid;
    while (excess[u] > 0) begin
      lowest = 0;
      found = 0;
      for (int v = 0; v < n; v++) begin
        if (!nbr[u][v]) continue;
        resid = cap_m[u][v] - flow_m[u][v];
        if (resid <= 0) continue;
        if (height[u] == height[v] + 1)
          move_flow(u, v, excess[u] < resid ? excess[u] : resid, s, t);
        if (!found || height[v] < lowest) lowest = height[v];
        found = 1;
        if (excess[u] == 0) return;
      end
      if (!found) return;
      height[u] = lowest >= 255 ? 255 : lowest + 1;
    end
  endfunction

  function automatic logic [OUT_W-1:0] max_flow_of_graph();
    int n, u;
    longint total;
    n = live_nodes();
    if (cfg_src >= n || cfg_snk >= n || cfg_src == cfg_snk) return '0;
    for (int i = 0; i < n; i++) begin
      excess[i] = 0;
      height[i] = 0;
      for (int j = 0; j < n; j++) flow_m[i][j] = 0;
    end
    q_head = 0;
    q_count = 0;
    height[cfg_src] = n;
    for (int v = 0; v < n; v++)
      if (nbr[cfg_src][v]) move_flow(cfg_src, v, cap_m[cfg_src][v], cfg_src, cfg_snk);
    while (q_count > 0) begin
      u = act_q[q_head];
      q_head = (q_head + 1) % NMAX;
      q_count--;
      if (u < n && u != cfg_src && u != cfg_snk) drain_node(u, n, cfg_src, cfg_snk);
    end
    total = -excess[cfg_src];
    return total > 0 ? total[OUT_W-1:0] : '0;
  endfunction

  function automatic void apply_item(logic [CMD_W-1:0] cmd, int a, int b, int w, bit one_way);
    int n;
    n = live_nodes();
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < n; i++) begin
          excess[i] = 0;
          height[i] = 0;
          for (int j = 0; j < n; j++) begin
            cap_m[i][j] = 0;
            flow_m[i][j] = 0;
            nbr[i][j] = 0;
          end
        end
        q_head = 0;
        q_count = 0;
      end
      CMD_ADD: begin
        if (a != b) begin
          nbr[a][b] = 1;
          nbr[b][a] = 1;
          cap_m[a][b] = cap_m[a][b] + w > CAP_MAX ? CAP_MAX : cap_m[a][b] + w;
          if (!one_way) cap_m[b][a] = cap_m[b][a] + w > CAP_MAX ? CAP_MAX : cap_m[b][a] + w;
        end
      end
      CMD_RUN: begin
        flows_due[due_wr % DUE_DEPTH] = max_flow_of_graph();
        due_wr++;
      end
      default: ;
    endcase
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    due_wr = 0;
    due_rd = 0;
    for (int i = 0; i < NMAX; i++) begin
      excess[i] = 0;
      height[i] = 0;
      for (int j = 0; j < NMAX; j++) begin
        cap_m[i][j] = 0;
        flow_m[i][j] = 0;
        nbr[i][j] = 0;
      end
    end
    q_head = 0;
    q_count = 0;
    cfg_nodes = 64;
    cfg_src = 0;
    cfg_snk = 63;
  end

  // observe config writes, accepted items and accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT: cfg_nodes = int'(cfg_data);
          CFG_SOURCE:     cfg_src = int'(cfg_data[NODE_IN_W-1:0]);
          CFG_SINK:       cfg_snk = int'(cfg_data[NODE_IN_W-1:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_wr == due_rd) report("unexpected result", out_max_flow, -1);
        else begin
          if (out_max_flow !== flows_due[due_rd % DUE_DEPTH])
            report("max_flow", out_max_flow, flows_due[due_rd % DUE_DEPTH]);
          due_rd++;
        end
      end
      if (in_valid && !in_stall)
        apply_item(in_cmd, in_from_node, in_to_node, in_edge_capacity, in_directed);
      pending = due_wr - due_rd;
    end
  end
endmodule

FILE: sim/tb.sv
// testbench top: stimulus, idling and verdict for the push-relabel max flow engine
module tb
  import prmf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1600;
  localparam int STUCK_LIMIT = 10000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd;
  logic [NODE_IN_W-1:0] in_from_node;
  logic [NODE_IN_W-1:0] in_to_node;
  logic [EDGE_W-1:0]    in_edge_capacity;
  logic                 in_directed;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     out_max_flow;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int errors, pending;
  int items_sent, runs_sent, settings_used, big_left, stuck_cycles;
  int send_idle_pct, recv_idle_pct;

  push_relabel_max_flow DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_from_node(in_from_node), .in_to_node(in_to_node),
    .in_edge_capacity(in_edge_capacity), .in_directed(in_directed),
    .out_valid(out_valid), .out_stall(out_stall), .out_max_flow(out_max_flow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  prmf_checker flow_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_from_node(in_from_node), .in_to_node(in_to_node),
    .in_edge_capacity(in_edge_capacity), .in_directed(in_directed),
    .out_valid(out_valid), .out_stall(out_stall), .out_max_flow(out_max_flow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk)
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout after %0d cycles with no item moving", stuck_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one item; returns at the edge where it was accepted
  task automatic send(input logic [CMD_W-1:0] cmd, input int a, input int b,
                      input int w, input bit one_way);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_from_node <= NODE_IN_W'(a);
    in_to_node <= NODE_IN_W'(b);
    in_edge_capacity <= EDGE_W'(w);
    in_directed <= one_way;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_RUN) runs_sent++;
    items_sent++;
  endtask

  task automatic run_flow();
    send(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535),
         $urandom_range(0, 1));
  endtask

  // write all three registers once the block is idle and every expected flow is back
  task automatic set_graph_cfg(input int n, input int s, input int t);
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0 || in_stall) @(negedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1; cfg_index <= CFG_NODE_COUNT; cfg_data <= CFG_W'(n);
    @(posedge clk);
    cfg_index <= CFG_SOURCE; cfg_data <= CFG_W'(s);
    @(posedge clk);
    cfg_index <= CFG_SINK; cfg_data <= CFG_W'(t);
    @(posedge clk);
    cfg_we <= 0;
    settings_used++;
  endtask

  function automatic int pick_cap();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(1, 20);
      2: return 65535;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // one setting, optional clear, a random graph with runs, closing run
  task automatic random_phase();
    int n, eff, s, t, edges, r, a, b;
    bit big;
    big = 0;
    if (big_left > 0 && $urandom_range(0, 19) == 0) begin
      big = 1;
      big_left--;
      n = $urandom_range(0, 1) ? 64 : 127;
    end else n = $urandom_range(2, 10);
    eff = n > 64 ? 64 : n;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      s = $urandom_range(0, eff - 1);
      t = s;
    end else if (r == 1) begin
      s = $urandom_range(0, 63);
      t = $urandom_range(0, 63);
    end else begin
      s = $urandom_range(0, eff - 1);
      t = (s + $urandom_range(1, eff - 1)) % eff;
    end
    set_graph_cfg(n, s, t);
    if ($urandom_range(0, 3) != 0)
      send(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535),
           $urandom_range(0, 1));
    edges = big ? 40 : $urandom_range(1, 3 * eff);
    for (int i = 0; i < edges; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 65535), $urandom_range(0, 1));
      else if (r < 12) send(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63),
                            pick_cap(), $urandom_range(0, 1));
      else if (r < 20 && !big) run_flow();
      else begin
        a = $urandom_range(0, eff - 1);
        b = $urandom_range(0, eff - 1);
        send(CMD_ADD, a, b, pick_cap(), $urandom_range(0, 1));
      end
    end
    run_flow();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_cmd = CMD_CLEAR;
    in_from_node = 0;
    in_to_node = 0;
    in_edge_capacity = 0;
    in_directed = 0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = CFG_NODE_COUNT;
    cfg_data = 0;
    stuck_cycles = 0;
    items_sent = 0;
    runs_sent = 0;
    settings_used = 0;
    big_left = 3;
    send_idle_pct = 26;
    recv_idle_pct = 50;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: saturation, self loop, unknown command, both directions
    send(CMD_ADD, 0, 33, 65535, 1);
    send(CMD_ADD, 0, 33, 100, 1);
    send(CMD_ADD, 33, 63, 40000, 0);
    send(CMD_ADD, 0, 62, 5, 0);
    send(CMD_ADD, 62, 63, 65535, 1);
    send(CMD_ADD, 7, 7, 1234, 0);
    send(CMD_UNUSED, 63, 63, 65535, 1);
    send(CMD_RUN, 0, 0, 0, 0);
    // partial clear keeps the higher nodes
    set_graph_cfg(4, 0, 3);
    send(CMD_CLEAR, 0, 0, 0, 0);
    send(CMD_ADD, 0, 1, 1, 1);
    send(CMD_ADD, 1, 3, 3, 0);
    send(CMD_RUN, 0, 0, 0, 0);
    set_graph_cfg(64, 0, 63);
    send(CMD_RUN, 0, 0, 0, 0);
    // node count above the maximum, terminals reversed
    set_graph_cfg(127, 63, 0);
    send(CMD_RUN, 0, 0, 0, 0);
    // source equals sink, then terminals outside the nodes in use
    set_graph_cfg(64, 33, 33);
    send(CMD_RUN, 0, 0, 0, 0);
    set_graph_cfg(2, 5, 1);
    send(CMD_RUN, 0, 0, 0, 0);
    set_graph_cfg(64, 0, 63);
    send(CMD_CLEAR, 0, 0, 0, 0);
    send(CMD_RUN, 63, 63, 65535, 1);

    // random graphs; idling pattern changes by thirds
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 50;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase();
    end
    in_valid <= 0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d items including %0d runs over %0d register settings",
             items_sent, runs_sent, settings_used);
    $display("graphs from 2 to 64 nodes, saturated capacities, bad terminals, idle and stall");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
